// ----- rtl/mixed_width_bitmap_text_renderer_core_assert.svh -----
// Assertion macros for the text renderer checkers.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MIXED_WIDTH_BITMAP_TEXT_RENDERER_CORE_ASSERT_SVH
`define MIXED_WIDTH_BITMAP_TEXT_RENDERER_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define MWBTR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mwbtr: assertion failed");

// Next-cycle implication, off during reset.
`define MWBTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mwbtr: assertion failed");

`endif

// ----- rtl/mwbtr_pkg.sv -----
// Shared types and constants of the mixed-width bitmap text renderer.
// No dependencies; used by the core and its checker.
`default_nettype none

package mwbtr_pkg;

  // Glyph geometry
  localparam int unsigned GLYPH_ROWS       = 16;
  localparam int unsigned ROW_W            = 4;
  localparam int unsigned CODES_PER_ROW    = 94;
  localparam int unsigned WIDE_GLYPH_BYTES = 2 * GLYPH_ROWS;
  localparam int unsigned WIDE_DEPTH       = CODES_PER_ROW * CODES_PER_ROW * WIDE_GLYPH_BYTES;
  localparam int unsigned CODE_W           = 14;
  localparam int unsigned CODE_OFF_W       = 7;

  // Parameter defaults
  localparam int unsigned NARROW_GLYPHS_DEF = 256;
  localparam int unsigned ADDRESS_BITS_DEF  = 24;

  // Field widths
  localparam int unsigned FONT_ADDR_W = 19;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PIX_W       = 24;
  localparam int unsigned MASK_W      = 16;
  localparam int unsigned PEN_W       = 24;
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned PITCH_W     = 13;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned PROD_W      = COORD_W + PITCH_W;

  // Stream packing
  localparam int unsigned S_TDATA_W  = 40;
  localparam int unsigned S_TUSER_W  = 2;
  localparam int unsigned M_TDATA_W  = 40;
  localparam int unsigned M_TUSER_W  = 2;
  localparam int unsigned FBYTE_LSB  = FONT_ADDR_W;
  localparam int unsigned TBYTE_LSB  = FONT_ADDR_W + BYTE_W;
  localparam int unsigned MASK_LSB   = PIX_W;
  localparam int unsigned TUSER_WIDE = 0;
  localparam int unsigned TUSER_BAD  = 1;

  // APB
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd1024;

  // Code ranges
  localparam logic [BYTE_W-1:0] LEAD_THRESHOLD = 8'h80;
  localparam logic [BYTE_W-1:0] CODE_FIRST     = 8'hA1;
  localparam logic [BYTE_W-1:0] CODE_LAST      = 8'hFE;

  // Pen advance per glyph
  localparam logic [PEN_W-1:0] NARROW_ADVANCE = 24'd8;
  localparam logic [PEN_W-1:0] WIDE_ADVANCE   = 24'd16;

  typedef enum logic [1:0] {
    CMD_NARROW_LOAD = 2'd0,
    CMD_WIDE_LOAD   = 2'd1,
    CMD_TEXT        = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_START_X    = 2'd0,
    REG_START_Y    = 2'd1,
    REG_LINE_PITCH = 2'd2,
    REG_PEN_COLOR  = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/mixed_width_bitmap_text_renderer_core.sv -----
// Mixed-width bitmap text renderer: 8x16 single-byte and 16x16 GB2312 glyphs.
// Uses mwbtr_pkg; font stores are inferred memories in this module.
//
// Items on the slave stream load font bytes (no result) or carry text bytes.
// A text byte that draws a glyph gives 16 row items on the master stream; an
// invalid double-byte code gives one flagged item, a lead byte gives none.
// A load, a lead byte or an unused command is accepted in the idle state and
// needs no further step. A glyph passes an accept step, then a step that forms
// the top-row address and reads the first font row, then one row per cycle
// while the master side is ready; a flagged code gives its single item. The
// row address adder (row address plus line pitch) and the one-row-per-cycle
// font read set this rate. The block does not accept input while rows are going out. Font
// stores have no reset and need no clearing pass.
`default_nettype none

module mixed_width_bitmap_text_renderer_core #(
  parameter int unsigned NARROW_GLYPHS = mwbtr_pkg::NARROW_GLYPHS_DEF,
  parameter int unsigned ADDRESS_BITS  = mwbtr_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // slave stream: tdata = font_address[18:0], font_byte[26:19], text_byte[34:27], zero pad
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [mwbtr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser = command[1:0]
  input  wire logic [mwbtr_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  input  wire logic                             s_axis_tlast,
  // master stream: tdata = pixel_address[23:0], row_mask[39:24]
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [mwbtr_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // tuser = wide_glyph[0], bad_code[1]
  output logic [mwbtr_pkg::M_TUSER_W-1:0]       m_axis_tuser,
  output logic                                  m_axis_tlast,
  // configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mwbtr_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [mwbtr_pkg::PDATA_W-1:0]    pwdata,
  output logic [mwbtr_pkg::PDATA_W-1:0]         prdata,
  output logic                                  pready
);
  import mwbtr_pkg::*;

  localparam int unsigned NARROW_DEPTH = NARROW_GLYPHS * GLYPH_ROWS;
  localparam int unsigned NIDX_W       = $clog2(NARROW_GLYPHS);
  localparam int unsigned NADDR_W      = NIDX_W + ROW_W;
  localparam int unsigned ACC_W        = ADDRESS_BITS;

  // Input fields
  logic [FONT_ADDR_W-1:0] font_address;
  logic [BYTE_W-1:0]      font_byte;
  logic [BYTE_W-1:0]      text_byte;
  cmd_e                   command;
  logic                   s_fire, m_fire;

  assign font_address = s_axis_tdata[FONT_ADDR_W-1:0];
  assign font_byte    = s_axis_tdata[FBYTE_LSB +: BYTE_W];
  assign text_byte    = s_axis_tdata[TBYTE_LSB +: BYTE_W];
  assign command      = cmd_e'(s_axis_tuser);

  // Control state
  state_e             state_q, state_d;
  logic               lead_q, lead_d;
  logic [BYTE_W-1:0]  prev_q, prev_d;
  logic [PEN_W-1:0]   pen_q, pen_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COORD_W-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [PITCH_W-1:0] pitch_q, pitch_d;
  logic [COLOR_W-1:0] color_q, color_d;

  // Per-glyph payload
  logic [PROD_W-1:0]  prod_q;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [NIDX_W-1:0]  nidx_q, nidx_d;
  logic               wide_q, wide_d, bad_q, bad_d, eos_q;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               ld_item;

  // Font stores
  logic [BYTE_W-1:0]  narrow_mem [NARROW_DEPTH];
  logic [BYTE_W-1:0]  wide_mem   [WIDE_DEPTH];
  logic [BYTE_W-1:0]  nrd_q, whi_q, wlo_q;
  logic               nwr_en, wwr_en, rd_en;
  logic [ROW_W-1:0]   rd_row;

  logic               cfg_wr;
  reg_e               cfg_idx;
  logic               is_multi, lead_ok, tail_ok, last_row;
  logic [BYTE_W-1:0]  lead_off, tail_off;
  logic [BYTE_W:0]    nidx_wide;
  logic [MASK_W-1:0]  row_mask;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign m_fire  = m_axis_tvalid && m_axis_tready;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_e'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  assign is_multi = (text_byte > LEAD_THRESHOLD) && (!s_axis_tlast || lead_q);
  assign lead_ok  = (prev_q >= CODE_FIRST) && (prev_q <= CODE_LAST);
  assign tail_ok  = (text_byte >= CODE_FIRST) && (text_byte <= CODE_LAST);
  assign lead_off = prev_q - CODE_FIRST;
  assign tail_off = text_byte - CODE_FIRST;
  // byte modulo glyph count: correct only for a byte below twice the count, which the block does not check
  assign nidx_wide = ({1'b0, text_byte} >= (BYTE_W+1)'(NARROW_GLYPHS))
                   ? ({1'b0, text_byte} - (BYTE_W+1)'(NARROW_GLYPHS))
                   : {1'b0, text_byte};

  assign nwr_en = s_fire && (command == CMD_NARROW_LOAD)
               && (font_address < FONT_ADDR_W'(NARROW_DEPTH));
  assign wwr_en = s_fire && (command == CMD_WIDE_LOAD)
               && (font_address < FONT_ADDR_W'(WIDE_DEPTH));

  // Sequencer
  always_comb begin
    state_d = state_q;
    lead_d  = lead_q;
    prev_d  = prev_q;
    pen_d   = pen_q;
    row_d   = row_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    pitch_d = pitch_q;
    color_d = color_q;
    acc_d   = acc_q;
    ld_item = 1'b0;
    rd_en   = 1'b0;
    rd_row  = '0;
    wide_d  = 1'b0;
    bad_d   = 1'b0;
    code_d  = CODE_W'(lead_off[CODE_OFF_W-1:0]) * CODE_W'(CODES_PER_ROW)
            + CODE_W'(tail_off[CODE_OFF_W-1:0]);
    nidx_d  = nidx_wide[NIDX_W-1:0];
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_EMIT);

    if (cfg_wr) begin
      case (cfg_idx)
        REG_START_X: begin
          sx_d  = pwdata[COORD_W-1:0];
          pen_d = PEN_W'(pwdata[COORD_W-1:0]);
        end
        REG_START_Y:    sy_d    = pwdata[COORD_W-1:0];
        REG_LINE_PITCH: pitch_d = pwdata[PITCH_W-1:0];
        REG_PEN_COLOR:  color_d = pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (s_fire && (command == CMD_TEXT)) begin
          prev_d = text_byte;
          if (is_multi && !lead_q) begin
            lead_d = 1'b1;
          end else begin
            ld_item = 1'b1;
            state_d = ST_BASE;
            if (is_multi) begin
              wide_d = 1'b1;
              bad_d  = !lead_ok || !tail_ok;
              lead_d = 1'b0;
            end
            if (s_axis_tlast) begin
              lead_d = 1'b0;
            end
          end
        end
      end
      ST_BASE: begin
        // top-row address, first font read, then move the pen
        acc_d   = ACC_W'(prod_q) + ACC_W'(pen_q);
        rd_en   = 1'b1;
        row_d   = '0;
        pen_d   = eos_q ? PEN_W'(sx_q) : (pen_q + (wide_q ? WIDE_ADVANCE : NARROW_ADVANCE));
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        rd_row = row_q + 1'b1;
        if (m_fire) begin
          if (last_row) begin
            state_d = ST_IDLE;
          end else begin
            rd_en = 1'b1;
            row_d = row_q + 1'b1;
            acc_d = acc_q + ACC_W'(pitch_q);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lead_q  <= 1'b0;
      prev_q  <= '0;
      pen_q   <= '0;
      row_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      pitch_q <= PITCH_RESET;
      color_q <= '0;
    end else begin
      state_q <= state_d;
      lead_q  <= lead_d;
      prev_q  <= prev_d;
      pen_q   <= pen_d;
      row_q   <= row_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      pitch_q <= pitch_d;
      color_q <= color_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ld_item) begin
      prod_q <= PROD_W'(sy_q) * PROD_W'(pitch_q);
      code_q <= code_d;
      nidx_q <= nidx_d;
      wide_q <= wide_d;
      bad_q  <= bad_d;
      eos_q  <= s_axis_tlast;
    end
  end

  // Font stores: one write port, registered reads
  always_ff @(posedge clk_i) begin
    if (nwr_en) begin
      narrow_mem[font_address[NADDR_W-1:0]] <= font_byte;
    end
    if (rd_en && !wide_q) begin
      nrd_q <= narrow_mem[{nidx_q, rd_row}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wwr_en) begin
      wide_mem[font_address] <= font_byte;
    end
    if (rd_en && wide_q && !bad_q) begin
      whi_q <= wide_mem[{code_q, rd_row, 1'b0}];
      wlo_q <= wide_mem[{code_q, rd_row, 1'b1}];
    end
  end

  // Result item
  assign last_row = bad_q || (row_q == ROW_W'(GLYPH_ROWS - 1));
  assign row_mask = bad_q ? '0 : (wide_q ? {whi_q, wlo_q} : {nrd_q, {BYTE_W{1'b0}}});

  assign m_axis_tdata = {row_mask, PIX_W'(acc_q)};
  assign m_axis_tuser = {bad_q, wide_q};
  assign m_axis_tlast = last_row;

  // Register read-back
  always_comb begin
    case (cfg_idx)
      REG_START_X:    prdata = PDATA_W'(sx_q);
      REG_START_Y:    prdata = PDATA_W'(sy_q);
      REG_LINE_PITCH: prdata = PDATA_W'(pitch_q);
      REG_PEN_COLOR:  prdata = PDATA_W'(color_q);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mwbtr_checker.sv -----
// Port-level checker for the text renderer core, bound to the core module.
// Uses mwbtr_pkg and the assertion macros header.
`default_nettype none

`include "mixed_width_bitmap_text_renderer_core_assert.svh"

module mwbtr_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [mwbtr_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [mwbtr_pkg::M_TUSER_W-1:0] m_axis_tuser,
  input wire logic                            m_axis_tlast
);
  import mwbtr_pkg::*;

  // hold a stalled result item
  `MWBTR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // no input is taken while rows are going out
  `MWBTR_ASSERT_NOW(a_one_item, m_axis_tvalid, !s_axis_tready)

  // a flagged code is a single empty wide item
  `MWBTR_ASSERT_NOW(a_bad_code, m_axis_tvalid && m_axis_tuser[TUSER_BAD], m_axis_tlast && m_axis_tuser[TUSER_WIDE] && (m_axis_tdata[MASK_LSB +: MASK_W] == '0))

  // narrow rows paint only the left eight pixels
  `MWBTR_ASSERT_NOW(a_narrow_row, m_axis_tvalid && !m_axis_tuser[TUSER_WIDE], (m_axis_tdata[MASK_LSB +: BYTE_W] == '0) && !m_axis_tuser[TUSER_BAD])

endmodule

bind mixed_width_bitmap_text_renderer_core mwbtr_checker u_mwbtr_checker (.*);

`default_nettype wire
